// File: rtl/core/mpct_pkg.sv
// ----------------------------------------------------------------------------
// mpct_pkg
// Shared types, constants and helpers of the mouse packet cursor tracker.
// ----------------------------------------------------------------------------
package mpct_pkg;

   // Cursor coordinate width; the screen may be at most 2**COORD_BITS wide.
   localparam int COORD_BITS = 12;
   localparam int SIZE_BITS  = COORD_BITS + 1;
   localparam int SUM_BITS   = COORD_BITS + 2;

   localparam int CSR_DATA_BITS = 13;
   localparam int CSR_ADDR_BITS = 1;

   // Register indexes.
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SCREEN_WIDTH  = 1'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SCREEN_HEIGHT = 1'd1;

   localparam logic [CSR_DATA_BITS-1:0] SCREEN_WIDTH_RESET  = 13'd1024;
   localparam logic [CSR_DATA_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd768;

   // Item kinds.
   localparam logic KIND_BYTE     = 1'b0;
   localparam logic KIND_RECENTER = 1'b1;

   // Result status codes.
   localparam logic [2:0] STATUS_PARTIAL  = 3'd0;
   localparam logic [2:0] STATUS_APPLIED  = 3'd1;
   localparam logic [2:0] STATUS_OVERFLOW = 3'd2;
   localparam logic [2:0] STATUS_NO_SYNC  = 3'd3;
   localparam logic [2:0] STATUS_RECENTER = 3'd4;

   // Byte phases within a packet.
   localparam logic [1:0] PHASE_FLAGS = 2'd0;
   localparam logic [1:0] PHASE_X     = 2'd1;
   localparam logic [1:0] PHASE_Y     = 2'd2;

   // Bit positions in the first byte of a packet.
   localparam int SYNC_BIT  = 3;
   localparam int XSIGN_BIT = 4;
   localparam int YSIGN_BIT = 5;
   localparam int XOVF_BIT  = 6;
   localparam int YOVF_BIT  = 7;

   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] cursor_x;
      logic [COORD_BITS-1:0] cursor_y;
      logic [2:0]            buttons;
      logic [2:0]            status;
   } rsp_type;

   // Screen limits derived from the size registers.
   typedef struct packed {
      logic [COORD_BITS-1:0] top_x;
      logic [COORD_BITS-1:0] top_y;
      logic [COORD_BITS-1:0] mid_x;
      logic [COORD_BITS-1:0] mid_y;
   } screen_type;

   // A size of zero counts as one; a size beyond the coordinate range is capped.
   function automatic logic [SIZE_BITS-1:0] eff_size(input logic [CSR_DATA_BITS-1:0] v);
      logic [31:0] wide;
      logic [31:0] lim;
      wide = 32'(v);
      lim  = 32'd1 << COORD_BITS;
      if (wide == 32'd0) begin
         return SIZE_BITS'(1);
      end else if (wide > lim) begin
         return SIZE_BITS'(lim);
      end
      return SIZE_BITS'(wide);
   endfunction

   function automatic logic [COORD_BITS-1:0] size_top(input logic [CSR_DATA_BITS-1:0] v);
      logic [SIZE_BITS-1:0] e;
      e = eff_size(v) - SIZE_BITS'(1);
      return e[COORD_BITS-1:0];
   endfunction

   function automatic logic [COORD_BITS-1:0] size_mid(input logic [CSR_DATA_BITS-1:0] v);
      logic [SIZE_BITS-1:0] e;
      e = eff_size(v) >> 1;
      return e[COORD_BITS-1:0];
   endfunction

endpackage

// File: rtl/core/mouse_packet_cursor_tracker.sv
// ----------------------------------------------------------------------------
// mouse_packet_cursor_tracker
// Assembles three-byte mouse packets and tracks a clamped cursor position.
// ----------------------------------------------------------------------------
//   port group | direction | handshake          | payload
//   req_       | in        | req_valid/req_stall | kind, rx_byte
//   rsp_       | out       | rsp_valid/rsp_stall | cursor_x, cursor_y, buttons, status
//   csr_       | in        | csr_we              | csr_addr, csr_wdata
//
// One item per cycle while no result is stalled; each item gives exactly one
// result, passing the input register, then the result register holding the update.
// Reset is synchronous: packet phase cleared, cursor centered on a 1024 x 768
// screen, no results pending. A stalled result holds the pipeline, and at most
// one further item is taken into the input register while it waits.
// ----------------------------------------------------------------------------
module mouse_packet_cursor_tracker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  mpct_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output mpct_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [mpct_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [mpct_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   mpct_pkg::screen_type screen;
   mpct_pkg::req_type    item;
   logic                 item_valid;
   logic                 advance;

   mpct_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .screen    (screen)
   );

   mpct_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   mpct_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .advance    (advance),
      .screen     (screen),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// File: rtl/core/mpct_csr.sv
// ----------------------------------------------------------------------------
// mpct_csr
// Screen size registers, kept as the clamp limit and the center point.
// ----------------------------------------------------------------------------
module mpct_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [mpct_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [mpct_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output mpct_pkg::screen_type                 screen
);

   mpct_pkg::screen_type screen_ff;
   mpct_pkg::screen_type screen_in;

   always_comb begin
      screen_in = screen_ff;
      if (csr_we) begin
         unique case (csr_addr)
            mpct_pkg::CSR_SCREEN_WIDTH: begin
               screen_in.top_x = mpct_pkg::size_top(csr_wdata);
               screen_in.mid_x = mpct_pkg::size_mid(csr_wdata);
            end
            mpct_pkg::CSR_SCREEN_HEIGHT: begin
               screen_in.top_y = mpct_pkg::size_top(csr_wdata);
               screen_in.mid_y = mpct_pkg::size_mid(csr_wdata);
            end
            default: begin
               screen_in = screen_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_ff.top_x <= mpct_pkg::size_top(mpct_pkg::SCREEN_WIDTH_RESET);
         screen_ff.mid_x <= mpct_pkg::size_mid(mpct_pkg::SCREEN_WIDTH_RESET);
         screen_ff.top_y <= mpct_pkg::size_top(mpct_pkg::SCREEN_HEIGHT_RESET);
         screen_ff.mid_y <= mpct_pkg::size_mid(mpct_pkg::SCREEN_HEIGHT_RESET);
      end else begin
         screen_ff <= screen_in;
      end
   end

   assign screen = screen_ff;

endmodule

// File: rtl/core/mpct_in_stage.sv
// ----------------------------------------------------------------------------
// mpct_in_stage
// Input register for incoming items.
// ----------------------------------------------------------------------------
module mpct_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mpct_pkg::req_type req_data,
   input  logic              advance,
   output logic              item_valid,
   output mpct_pkg::req_type item
);

   logic              valid_ff;
   logic              valid_in;
   mpct_pkg::req_type item_ff;
   logic              accept;

   // The held item leaves whenever the tracker can take it, so a new one may
   // enter in the same cycle.
   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: rtl/core/mpct_tracker.sv
// ----------------------------------------------------------------------------
// mpct_tracker
// Packet assembly, cursor update and the result register.
// ----------------------------------------------------------------------------
module mpct_tracker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  mpct_pkg::req_type    item,
   output logic                 advance,
   input  mpct_pkg::screen_type screen,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mpct_pkg::rsp_type    rsp_data
);

   localparam int CB = mpct_pkg::COORD_BITS;
   localparam int SW = mpct_pkg::SUM_BITS;

   logic [1:0]    phase_ff, phase_in;
   logic [7:0]    flag_ff, flag_in;
   logic [7:0]    xmove_ff, xmove_in;
   logic [CB-1:0] pos_x_ff, pos_x_in;
   logic [CB-1:0] pos_y_ff, pos_y_in;
   logic [2:0]    btn_ff, btn_in;
   logic          rsp_valid_ff, rsp_valid_in;
   mpct_pkg::rsp_type rsp_ff, rsp_in;
   logic [2:0]    status;
   logic          fire;

   logic signed [8:0]    dx;
   logic signed [8:0]    dy;
   logic signed [SW-1:0] sum_x;
   logic signed [SW-1:0] sum_y;
   logic [CB-1:0]        clamp_x;
   logic [CB-1:0]        clamp_y;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign fire    = item_valid && advance;

   // Nine-bit signed moves: low byte from the packet, sign from the flags.
   assign dx    = {flag_ff[mpct_pkg::XSIGN_BIT], xmove_ff};
   assign dy    = {flag_ff[mpct_pkg::YSIGN_BIT], item.rx_byte};
   assign sum_x = $signed({2'b00, pos_x_ff}) + SW'(dx);
   assign sum_y = $signed({2'b00, pos_y_ff}) - SW'(dy);

   always_comb begin
      if (sum_x < 0) begin
         clamp_x = '0;
      end else if (sum_x > $signed({2'b00, screen.top_x})) begin
         clamp_x = screen.top_x;
      end else begin
         clamp_x = sum_x[CB-1:0];
      end
      if (sum_y < 0) begin
         clamp_y = '0;
      end else if (sum_y > $signed({2'b00, screen.top_y})) begin
         clamp_y = screen.top_y;
      end else begin
         clamp_y = sum_y[CB-1:0];
      end
   end

   always_comb begin
      phase_in = phase_ff;
      flag_in  = flag_ff;
      xmove_in = xmove_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      btn_in   = btn_ff;
      status   = mpct_pkg::STATUS_PARTIAL;
      if (item.kind == mpct_pkg::KIND_RECENTER) begin
         // A packet in progress is left as it is.
         pos_x_in = screen.mid_x;
         pos_y_in = screen.mid_y;
         status   = mpct_pkg::STATUS_RECENTER;
      end else begin
         unique case (phase_ff)
            mpct_pkg::PHASE_X: begin
               xmove_in = item.rx_byte;
               phase_in = mpct_pkg::PHASE_Y;
            end
            mpct_pkg::PHASE_Y: begin
               phase_in = mpct_pkg::PHASE_FLAGS;
               if (flag_ff[mpct_pkg::XOVF_BIT] || flag_ff[mpct_pkg::YOVF_BIT]) begin
                  status = mpct_pkg::STATUS_OVERFLOW;
               end else begin
                  pos_x_in = clamp_x;
                  pos_y_in = clamp_y;
                  btn_in   = flag_ff[2:0];
                  status   = mpct_pkg::STATUS_APPLIED;
               end
            end
            default: begin
               // Flag byte; the unused phase is treated the same way.
               if (!item.rx_byte[mpct_pkg::SYNC_BIT]) begin
                  phase_in = mpct_pkg::PHASE_FLAGS;
                  status   = mpct_pkg::STATUS_NO_SYNC;
               end else begin
                  flag_in  = item.rx_byte;
                  phase_in = mpct_pkg::PHASE_X;
               end
            end
         endcase
      end
   end

   always_comb begin
      rsp_in.cursor_x = pos_x_in;
      rsp_in.cursor_y = pos_y_in;
      rsp_in.buttons  = btn_in;
      rsp_in.status   = status;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= mpct_pkg::PHASE_FLAGS;
         flag_ff      <= '0;
         xmove_ff     <= '0;
         pos_x_ff     <= mpct_pkg::size_mid(mpct_pkg::SCREEN_WIDTH_RESET);
         pos_y_ff     <= mpct_pkg::size_mid(mpct_pkg::SCREEN_HEIGHT_RESET);
         btn_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            phase_ff <= phase_in;
            flag_ff  <= flag_in;
            xmove_ff <= xmove_in;
            pos_x_ff <= pos_x_in;
            pos_y_ff <= pos_y_in;
            btn_ff   <= btn_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
